>>> hdl/csd_pkg.sv
package csd_pkg;

  localparam int COUNT_BITS       = 10;
  localparam int WINDOW_DEPTH_DEF = 512;
  localparam int FILL_BITS_DEF    = $clog2(WINDOW_DEPTH_DEF + 1);
  localparam int SUM_BITS_DEF     = COUNT_BITS + FILL_BITS_DEF;

  localparam int LIMIT_BITS     = 9;
  localparam int SCALE_BITS     = 12;
  localparam int THRESH_BITS    = 8;
  localparam int RUN_BITS       = 9;
  localparam int FILL_OUT_BITS  = 10;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 12;

  localparam logic [LIMIT_BITS-1:0]  LIMIT_RST  = 9'd300;
  localparam logic [SCALE_BITS-1:0]  SCALE_RST  = 12'd384;
  localparam logic [THRESH_BITS-1:0] THRESH_RST = 8'd8;
  localparam logic                   PAUSE_ON_DETECT_RST = 1'b0;

  localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

  typedef enum logic [1:0] {
    OP_SAMPLE       = 2'd0,
    OP_TOGGLE_PAUSE = 2'd1,
    OP_CLEAR        = 2'd2,
    OP_NOP          = 2'd3
  } opcode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WINDOW_LIMIT    = 2'd0,
    REG_SCALE_Q8        = 2'd1,
    REG_RUN_THRESHOLD   = 2'd2,
    REG_PAUSE_ON_DETECT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    opcode_t                opcode;
    logic [COUNT_BITS-1:0]  sample_count;
  } in_item_t;

  typedef struct packed {
    logic                     detected;
    logic                     paused_now;
    logic [RUN_BITS-1:0]      run_level;
    logic [FILL_OUT_BITS-1:0] window_fill;
  } out_item_t;

endpackage

>>> hdl/count_spike_detector.sv
// Spike detector on per-frame object counts. Each beat carries an opcode and a count;
// every beat returns exactly one result beat with the detection flag, the pause flag,
// the run counter and the window fill after that beat. The count window lives in a
// RAM of WINDOW_DEPTH entries with one write port and a registered read port.
// An item goes in steps: the accept edge reads the oldest count from the window RAM,
// and the finish edge drops it if the window is full, runs the mean test, writes the
// new count and updates sum, fill and run counter. A new item is taken only after
// the previous one finishes; the RAM read-modify-write requires it. A result waiting
// on out_ready does not block the next accept, only the finish of the following item.
// The window needs no clearing pass after reset: only entries in the fill are used.
module count_spike_detector
  import csd_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_data
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = COUNT_BITS + FW;
  localparam int CW = (FW > LIMIT_BITS) ? FW : LIMIT_BITS;
  localparam logic [CW-1:0] LIMIT_MAX  = CW'(WINDOW_DEPTH - 1);
  localparam logic [AW-1:0] PTR_LAST   = AW'(WINDOW_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_WRAP = (AW + 1)'(WINDOW_DEPTH);
  localparam logic [FW-1:0] SHORT_FILL = FW'(2);

  // configuration
  logic [LIMIT_BITS-1:0]  window_limit;
  logic [SCALE_BITS-1:0]  scale_q8;
  logic [THRESH_BITS-1:0] run_threshold;
  logic                   pause_on_detect;

  // detector state
  logic [COUNT_BITS-1:0] count_window [WINDOW_DEPTH];
  logic [AW-1:0]         oldest_ptr, oldest_ptr_next;
  logic [FW-1:0]         fill, fill_next;
  logic [SW-1:0]         window_sum, window_sum_next;
  logic [RUN_BITS-1:0]   run_counter, run_counter_next;
  logic                  paused, paused_next;

  // pipeline
  logic                  busy;
  logic                  finish;
  in_item_t              item;
  logic [COUNT_BITS-1:0] rd_data;
  out_item_t             result;

  // sample path
  logic [CW-1:0]   lim_eff;
  logic            drop;
  logic            do_sample;
  logic            hit;
  logic            det;
  logic [FW-1:0]   fill_mid;
  logic [FW-1:0]   fill_inc;
  logic [SW-1:0]   sum_mid;
  logic [AW-1:0]   ptr_mid;
  logic [AW:0]     wr_sum;
  logic [AW-1:0]   wr_addr;
  logic [RUN_BITS-1:0] run_upd;

  assign in_ready = !busy;
  assign finish   = busy && (!out_valid || out_ready);

  assign lim_eff   = (CW'(window_limit) > LIMIT_MAX) ? LIMIT_MAX : CW'(window_limit);
  assign drop      = CW'(fill) > lim_eff;
  assign fill_mid  = fill - FW'(drop);
  assign fill_inc  = fill_mid + FW'(1);
  assign sum_mid   = drop ? (window_sum - SW'(rd_data)) : window_sum;
  assign ptr_mid   = drop ? ((oldest_ptr == PTR_LAST) ? '0 : oldest_ptr + 1'b1) : oldest_ptr;
  assign wr_sum    = {1'b0, ptr_mid} + (AW + 1)'(fill_mid);
  assign wr_addr   = (wr_sum >= DEPTH_WRAP) ? AW'(wr_sum - DEPTH_WRAP) : wr_sum[AW-1:0];
  assign do_sample = (item.opcode == OP_SAMPLE) && !paused;

  csd_spike_test #(
    .FILL_BITS (FW),
    .SUM_BITS  (SW)
  ) u_test (
    .sample   (item.sample_count),
    .others   (fill_mid),
    .prev_sum (sum_mid),
    .scale_q8 (scale_q8),
    .hit      (hit)
  );

  always_comb begin
    run_upd = run_counter;
    if (fill_inc > SHORT_FILL) begin
      if (hit) begin
        if (run_counter != RUN_MAX) begin
          run_upd = run_counter + 1'b1;
        end
      end else if (run_counter < RUN_BITS'(2)) begin
        run_upd = '0;
      end else begin
        run_upd = run_counter - 1'b1;
      end
    end
  end

  always_comb begin
    oldest_ptr_next  = oldest_ptr;
    fill_next        = fill;
    window_sum_next  = window_sum;
    run_counter_next = run_counter;
    paused_next      = paused;
    det              = 1'b0;
    case (item.opcode)
      OP_SAMPLE: begin
        if (!paused) begin
          det = run_upd > RUN_BITS'(run_threshold);
          if (det) begin
            oldest_ptr_next  = '0;
            fill_next        = '0;
            window_sum_next  = '0;
            run_counter_next = '0;
            paused_next      = paused | pause_on_detect;
          end else begin
            oldest_ptr_next  = ptr_mid;
            fill_next        = fill_inc;
            window_sum_next  = sum_mid + SW'(item.sample_count);
            run_counter_next = run_upd;
          end
        end
      end
      OP_TOGGLE_PAUSE: paused_next = !paused;
      OP_CLEAR: begin
        oldest_ptr_next = '0;
        fill_next       = '0;
        window_sum_next = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    result.detected    = det;
    result.paused_now  = paused_next;
    result.run_level   = run_counter_next;
    result.window_fill = FILL_OUT_BITS'(fill_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit    <= LIMIT_RST;
      scale_q8        <= SCALE_RST;
      run_threshold   <= THRESH_RST;
      pause_on_detect <= PAUSE_ON_DETECT_RST;
      oldest_ptr      <= '0;
      fill            <= '0;
      window_sum      <= '0;
      run_counter     <= '0;
      paused          <= 1'b0;
      busy            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_WINDOW_LIMIT:    window_limit    <= cfg_data[LIMIT_BITS-1:0];
          REG_SCALE_Q8:        scale_q8        <= cfg_data[SCALE_BITS-1:0];
          REG_RUN_THRESHOLD:   run_threshold   <= cfg_data[THRESH_BITS-1:0];
          REG_PAUSE_ON_DETECT: pause_on_detect <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        oldest_ptr  <= oldest_ptr_next;
        fill        <= fill_next;
        window_sum  <= window_sum_next;
        run_counter <= run_counter_next;
        paused      <= paused_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and window RAM
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (finish) begin
      out_data <= result;
    end
    if (finish && do_sample) begin
      count_window[wr_addr] <= item.sample_count;
    end
    // oldest_ptr only moves on a finish edge, so the read after accept is current
    rd_data <= count_window[oldest_ptr];
  end

endmodule

>>> hdl/csd_spike_test.sv
module csd_spike_test
  import csd_pkg::*;
#(
  parameter int FILL_BITS = FILL_BITS_DEF,
  parameter int SUM_BITS  = SUM_BITS_DEF
) (
  input  logic [COUNT_BITS-1:0] sample,
  input  logic [FILL_BITS-1:0]  others,
  input  logic [SUM_BITS-1:0]   prev_sum,
  input  logic [SCALE_BITS-1:0] scale_q8,
  output logic                  hit
);

  localparam int MW = COUNT_BITS + FILL_BITS;
  localparam int LW = MW + 8;
  localparam int RW = SUM_BITS + SCALE_BITS;
  localparam int PW = (LW > RW) ? LW : RW;

  logic [MW-1:0] weighted;
  logic [RW-1:0] scaled_sum;

  // newest * (n-1) * 256 against sum of the others * scale: mean test without a divide
  assign weighted   = MW'(sample) * MW'(others);
  assign scaled_sum = RW'(prev_sum) * RW'(scale_q8);
  assign hit        = PW'({weighted, 8'b0}) > PW'(scaled_sum);

endmodule

>>> hdl/csd_checker.sv
module csd_checker
  import csd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a detection empties the window and the run counter
  a_detect_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.detected |-> out_data.run_level == '0 && out_data.window_fill == '0)
    else $error("detection beat with nonzero run level or fill");

  // one item at a time: no accept on the edge right after an accept
  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive edges");

  // a result only follows an accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result beat without an item in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind count_spike_detector csd_checker u_csd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> verif/spike_result_checker.sv
`timescale 1ns / 1ps

module spike_result_checker
  import csd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  in_item_t                  in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  out_item_t                 out_data,
  output int                        mismatches,
  output int                        results_due,
  output int                        results_seen,
  output int                        detections,
  output logic                      paused_expected
);

  // register copies
  logic [LIMIT_BITS-1:0]  limit_reg;
  logic [SCALE_BITS-1:0]  scale_reg;
  logic [THRESH_BITS-1:0] thresh_reg;
  logic                   pause_on_hit_reg;

  // detector state
  logic [COUNT_BITS-1:0]    counts [WINDOW_DEPTH_DEF];
  logic [LIMIT_BITS-1:0]    head;
  logic [FILL_OUT_BITS-1:0] fill;
  longint                   total;
  logic [RUN_BITS-1:0]      run;
  logic                     paused;

  out_item_t result_fifo [$];
  int        err_cnt;

  function automatic out_item_t step_detector(in_item_t beat);
    out_item_t r;
    logic      det;
    logic      hit;
    longint    prior;
    det = 1'b0;
    case (beat.opcode)
      OP_SAMPLE: begin
        if (!paused) begin
          // limit register is 9 bits, so it never exceeds the ring size
          if (fill > limit_reg) begin
            total -= counts[head];
            head = head + 1'b1;
            fill = fill - 1'b1;
          end
          prior = total;
          counts[LIMIT_BITS'(head + fill)] = beat.sample_count;
          fill = fill + 1'b1;
          total += beat.sample_count;
          if (fill > 2) begin
            hit = (longint'(beat.sample_count) * (longint'(fill) - 1) * 256) >
                  (prior * longint'(scale_reg));
            if (hit) begin
              if (run != RUN_MAX) run = run + 1'b1;
            end else if (run < 2) begin
              run = '0;
            end else begin
              run = run - 1'b1;
            end
          end
          if (run > thresh_reg) begin
            det = 1'b1;
            head = '0;
            fill = '0;
            total = 0;
            run = '0;
            if (pause_on_hit_reg) paused = 1'b1;
          end
        end
      end
      OP_TOGGLE_PAUSE: paused = ~paused;
      OP_CLEAR: begin
        head = '0;
        fill = '0;
        total = 0;
      end
      default: ;
    endcase
    r.detected    = det;
    r.paused_now  = paused;
    r.run_level   = run;
    r.window_fill = fill;
    return r;
  endfunction

  task automatic check_field(string name, logic [9:0] want, logic [9:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      limit_reg        = LIMIT_RST;
      scale_reg        = SCALE_RST;
      thresh_reg       = THRESH_RST;
      pause_on_hit_reg = PAUSE_ON_DETECT_RST;
      head   = '0;
      fill   = '0;
      total  = 0;
      run    = '0;
      paused = 1'b0;
      result_fifo.delete();
      err_cnt = 0;
      results_seen <= 0;
      detections   <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_WINDOW_LIMIT:    limit_reg        = cfg_data[LIMIT_BITS-1:0];
          REG_SCALE_Q8:        scale_reg        = cfg_data[SCALE_BITS-1:0];
          REG_RUN_THRESHOLD:   thresh_reg       = cfg_data[THRESH_BITS-1:0];
          REG_PAUSE_ON_DETECT: pause_on_hit_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) result_fifo = {result_fifo, step_detector(in_data)};
      if (out_valid && out_ready) begin
        if (result_fifo.size() == 0) begin
          $error("result beat with nothing predicted: %p", out_data);
          err_cnt++;
        end else begin
          want = result_fifo.pop_front();
          check_field("detected", 10'(want.detected), 10'(out_data.detected));
          check_field("paused_now", 10'(want.paused_now), 10'(out_data.paused_now));
          check_field("run_level", 10'(want.run_level), 10'(out_data.run_level));
          check_field("window_fill", 10'(want.window_fill), 10'(out_data.window_fill));
          results_seen <= results_seen + 1;
          if (want.detected) detections <= detections + 1;
        end
      end
    end
    mismatches      <= err_cnt;
    results_due     <= result_fifo.size();
    paused_expected <= paused;
  end

endmodule

>>> verif/tb_count_spike_detector.sv
`timescale 1ns / 1ps

module tb_count_spike_detector;
  import csd_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 90;

  logic                      clk;
  logic                      rst;
  logic                      cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  in_item_t                  in_data;
  logic                      out_valid;
  logic                      out_ready;
  out_item_t                 out_data;

  int   mismatches;
  int   results_due;
  int   results_seen;
  int   detections;
  logic paused_expected;

  int   cycle_count = 0;
  int   items_sent  = 0;
  int   settings    = 0;
  bit   calm        = 1'b0;
  bit   hold_req    = 1'b0;

  count_spike_detector uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  spike_result_checker chk (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatches      (mismatches),
    .results_due     (results_due),
    .results_seen    (results_seen),
    .detections      (detections),
    .paused_expected (paused_expected)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 19);
        @(posedge clk);
      end
    end
  end

  task automatic offer(opcode_t op, logic [COUNT_BITS-1:0] cnt);
    bit ignored;
    if (!calm) begin
      while ($urandom_range(99) < 19) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    ignored = (op == OP_SAMPLE) && paused_expected;
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, sample_count: cnt};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!ignored) items_sent++;
  endtask

  // wait until every beat in flight has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(int lim, int scale, int thresh, int pause_on_hit);
    put_reg(REG_WINDOW_LIMIT, CFG_DATA_BITS'(lim));
    put_reg(REG_SCALE_Q8, CFG_DATA_BITS'(scale));
    put_reg(REG_RUN_THRESHOLD, CFG_DATA_BITS'(thresh));
    put_reg(REG_PAUSE_ON_DETECT, CFG_DATA_BITS'(pause_on_hit));
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  // quiet baseline followed by a fast ramp, the shape that builds a run
  task automatic spike_burst();
    int base_len;
    int rise_len;
    int level;
    if (paused_expected) offer(OP_TOGGLE_PAUSE, COUNT_BITS'($urandom));
    base_len = $urandom_range(2, 8);
    rise_len = $urandom_range(2, 12);
    repeat (base_len) offer(OP_SAMPLE, COUNT_BITS'($urandom_range(0, 40)));
    level = $urandom_range(20, 80);
    repeat (rise_len) begin
      level = level + (level * $urandom_range(4, 12)) / 8 + $urandom_range(0, 20);
      if (level > 1023) level = 1023;
      offer(OP_SAMPLE, COUNT_BITS'(level));
    end
  endtask

  task automatic noise_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70)      offer(OP_SAMPLE, COUNT_BITS'($urandom));
    else if (pick < 80) offer(OP_TOGGLE_PAUSE, COUNT_BITS'($urandom));
    else if (pick < 90) offer(OP_CLEAR, COUNT_BITS'($urandom));
    else                offer(OP_NOP, COUNT_BITS'($urandom));
  endtask

  task automatic run_phase(int n);
    int goal;
    goal = items_sent + n;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 75) spike_burst();
      else noise_item();
    end
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_WINDOW_LIMIT;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, settings from reset
    offer(OP_NOP, 10'h3FF);
    offer(OP_SAMPLE, 10'd0);
    offer(OP_SAMPLE, 10'd1023);
    offer(OP_SAMPLE, 10'd0);
    offer(OP_SAMPLE, 10'd1023);
    offer(OP_TOGGLE_PAUSE, 10'd0);
    offer(OP_SAMPLE, 10'd500);      // dropped while paused
    offer(OP_TOGGLE_PAUSE, 10'h3FF);
    offer(OP_CLEAR, 10'h155);
    offer(OP_SAMPLE, 10'd5);        // short window, run left alone
    offer(OP_SAMPLE, 10'd900);

    // full window, then a detection that pauses
    settle();
    program_regs(3, 384, 1, 1);
    offer(OP_SAMPLE, 10'd10);
    offer(OP_SAMPLE, 10'd10);
    offer(OP_SAMPLE, 10'd10);
    offer(OP_SAMPLE, 10'd10);
    offer(OP_SAMPLE, 10'd200);
    offer(OP_SAMPLE, 10'd400);
    offer(OP_SAMPLE, 10'd700);
    offer(OP_TOGGLE_PAUSE, 10'h2AA);

    // small window limit, starting from the window emptied by the detection
    settle();
    program_regs(1, 384, 8, 0);
    offer(OP_SAMPLE, 10'd50);
    offer(OP_SAMPLE, 10'd60);

    settle();
    program_regs(0, 4095, 0, 1);
    run_phase(100);

    settle();
    program_regs(511, 0, 255, 0);
    run_phase(100);

    settle();
    program_regs(7, 256, 2, 1);
    calm = 1'b1;
    run_phase(100);

    // long receiver hold-off while items keep coming
    hold_req = 1'b1;
    repeat (40) offer(OP_SAMPLE, COUNT_BITS'($urandom));
    calm = 1'b0;

    settle();
    program_regs(3, 128, 1, 0);
    run_phase(100);

    settle();
    program_regs($urandom_range(1, 60), $urandom_range(64, 700),
                 $urandom_range(0, 6), $urandom_range(0, 1));
    run_phase(100);

    settle();
    program_regs($urandom_range(2, 30), $urandom_range(100, 500),
                 $urandom_range(0, 4), $urandom_range(0, 1));
    run_phase(100);

    settle();
    repeat (10) @(posedge clk);

    $display("Sent %0d items under %0d register settings; %0d results checked, %0d detections.",
             items_sent, settings, results_seen, detections);
    if (mismatches == 0 && results_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
